>>> rtl/odd_sieve_prime_test_core_assert.svh
// Assertion macros used by the controller RTL of the odd sieve prime test core.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ODD_SIEVE_PRIME_TEST_CORE_ASSERT_SVH
`define ODD_SIEVE_PRIME_TEST_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Overlapping implication, checked outside reset.
`define OSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define OSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define OSP_ASSERT_NOW(label, ante, cons)
`define OSP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/osp_pkg.sv
package osp_pkg;

  // Source of the bitmap read address.
  typedef enum logic [0:0] {
    RD_IDX = 1'b0,
    RD_NUM = 1'b1
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clr_step;
    logic    strike_init;
    logic    strike_step;
    logic    advance;
    logic    load_n;
    logic    td_init;
    logic    div_start;
    logic    div_step;
    rd_sel_t rd_sel;
  } osp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic sv_end;
    logic strike_last;
    logic rbit;
    logic n_two;
    logic n_zero_res;
    logic n_in_table;
    logic psq_gt_n;
    logic idx_in_table;
    logic div_last;
    logic div_zero;
  } osp_sts_t;

endpackage

>>> rtl/osp_ram.sv
module osp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/osp_dp.sv
module osp_dp
  import osp_pkg::*;
#(
  parameter int TABLE_ENTRIES = 1048576,
  parameter int NUMBER_BITS   = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [30:0] number,
  input  osp_cmd_t    cmd,
  output osp_sts_t    sts
);

  localparam int IW = NUMBER_BITS;
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int PW = (AW + 3 > IW + 2) ? AW + 3 : IW + 2;
  localparam int XW = (AW + 1 > IW) ? AW + 1 : IW;
  localparam int CW = $clog2(IW);
  localparam int MW = AW + 1;

  logic [IW-1:0] n;
  logic [PW-1:0] p;
  logic [PW-1:0] psq;
  logic [XW-1:0] idx;
  logic [MW-1:0] m;
  logic [IW-1:0] r;
  logic [IW-1:0] q;
  logic [CW-1:0] cnt;

  logic [IW+30:0] num_ext;
  logic [IW-1:0]  n_in;
  logic [IW:0]    rs;
  logic [IW:0]    pd;
  logic [IW-1:0]  r_next;
  logic [63:0]    n_idx;
  logic [PW-1:0]  sq_idx;
  logic [MW:0]    m_step;
  logic           we;
  logic [AW-1:0]  raddr;
  logic           rdata;

  assign num_ext = {{IW{1'b0}}, number};
  assign n_in    = num_ext[IW-1:0];

  // One restoring division step.
  assign rs     = {r, q[IW-1]};
  assign pd     = p[IW:0];
  assign r_next = (rs >= pd) ? IW'(rs - pd) : rs[IW-1:0];

  assign n_idx  = (64'(n) - 64'd3) >> 1;
  assign sq_idx = (psq - PW'(3)) >> 1;
  assign m_step = (MW+1)'(m) + (MW+1)'(p);

  assign sts.clr_last     = (m == MW'(TABLE_ENTRIES - 1));
  assign sts.sv_end       = (sq_idx >= PW'(TABLE_ENTRIES));
  assign sts.strike_last  = (m_step >= (MW+1)'(TABLE_ENTRIES));
  assign sts.rbit         = rdata;
  assign sts.n_two        = (n == IW'(2));
  assign sts.n_zero_res   = (n < IW'(2)) || !n[0];
  assign sts.n_in_table   = (n_idx < 64'(TABLE_ENTRIES));
  assign sts.psq_gt_n     = (psq > PW'(n));
  assign sts.idx_in_table = (idx < XW'(TABLE_ENTRIES));
  assign sts.div_last     = (cnt == CW'(IW - 1));
  assign sts.div_zero     = (r_next == '0);

  assign we    = cmd.clr_step || cmd.strike_step;
  assign raddr = (cmd.rd_sel == RD_NUM) ? n_idx[AW-1:0] : idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m   <= '0;
      p   <= PW'(3);
      psq <= PW'(9);
      idx <= '0;
    end else begin
      if (cmd.clr_step) begin
        m <= m + MW'(1);
      end
      if (cmd.strike_init) begin
        m <= sq_idx[MW-1:0];
      end
      if (cmd.strike_step) begin
        m <= m_step[MW-1:0];
      end
      if (cmd.td_init) begin
        p   <= PW'(3);
        psq <= PW'(9);
        idx <= '0;
      end else if (cmd.advance) begin
        // (p+2)^2 = p^2 + 4p + 4
        p   <= p + PW'(2);
        psq <= psq + (p << 2) + PW'(4);
        idx <= idx + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_n) begin
      n <= n_in;
    end
    if (cmd.div_start) begin
      r   <= '0;
      q   <= n;
      cnt <= '0;
    end else if (cmd.div_step) begin
      r   <= r_next;
      q   <= q << 1;
      cnt <= cnt + CW'(1);
    end
  end

  osp_ram #(
    .WIDTH(1),
    .DEPTH(TABLE_ENTRIES)
  ) u_map (
    .clk  (clk),
    .we   (we),
    .waddr(m[AW-1:0]),
    .wdata(cmd.clr_step),
    .raddr(raddr),
    .rdata(rdata)
  );

endmodule

>>> rtl/osp_ctrl.sv
`include "odd_sieve_prime_test_core_assert.svh"

module osp_ctrl
  import osp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     is_prime,
  output osp_cmd_t cmd,
  input  osp_sts_t sts
);

  typedef enum logic [10:0] {
    S_CLR    = 11'b00000000001,
    S_SV_RD  = 11'b00000000010,
    S_SV_WT  = 11'b00000000100,
    S_STRIKE = 11'b00000001000,
    S_IDLE   = 11'b00000010000,
    S_CLASS  = 11'b00000100000,
    S_LK_WT  = 11'b00001000000,
    S_TD_CHK = 11'b00010000000,
    S_TD_WT  = 11'b00100000000,
    S_DIV    = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic   res, res_next;
  logic   out_load;

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    res_next   = res;
    cmd        = '0;
    cmd.rd_sel = RD_IDX;
    case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_SV_RD;
        end
      end
      S_SV_RD: begin
        state_next = sts.sv_end ? S_IDLE : S_SV_WT;
      end
      S_SV_WT: begin
        if (sts.rbit) begin
          cmd.strike_init = 1'b1;
          state_next      = S_STRIKE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_SV_RD;
        end
      end
      S_STRIKE: begin
        cmd.strike_step = 1'b1;
        if (sts.strike_last) begin
          cmd.advance = 1'b1;
          state_next  = S_SV_RD;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_n = 1'b1;
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        if (sts.n_two) begin
          res_next   = 1'b1;
          state_next = S_DONE;
        end else if (sts.n_zero_res) begin
          res_next   = 1'b0;
          state_next = S_DONE;
        end else if (sts.n_in_table) begin
          cmd.rd_sel = RD_NUM;
          state_next = S_LK_WT;
        end else begin
          cmd.td_init = 1'b1;
          state_next  = S_TD_CHK;
        end
      end
      S_LK_WT: begin
        res_next   = sts.rbit;
        state_next = S_DONE;
      end
      S_TD_CHK: begin
        if (sts.psq_gt_n) begin
          res_next   = 1'b1;
          state_next = S_DONE;
        end else if (sts.idx_in_table) begin
          state_next = S_TD_WT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_TD_WT: begin
        if (sts.rbit) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_TD_CHK;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          if (sts.div_zero) begin
            res_next   = 1'b0;
            state_next = S_DONE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_TD_CHK;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (out_load) begin
      is_prime <= res;
    end
  end

  `OSP_ASSERT_NEXT(a_div_exit, (state == S_DIV) && sts.div_last,
                   (state == S_DONE) || (state == S_TD_CHK))
  `OSP_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `OSP_ASSERT_NOW(a_no_result_in_build,
                  (state == S_CLR) || (state == S_STRIKE) || (state == S_SV_RD),
                  !out_valid)

endmodule

>>> rtl/odd_sieve_prime_test_core.sv
// Odd-only sieve prime tester. After reset the core first sweeps the whole
// bitmap to ones and then runs the sieve: it reads the bit of each odd
// candidate below sqrt(2*TABLE_ENTRIES) and, for a candidate still marked,
// strikes its odd multiples from its square on. in_ready stays low until
// that build is finished; queries simply wait. One query is worked at a
// time. A value of 2, below 2 or even is answered from its class alone; an
// odd value inside the table is answered by one registered bitmap read. A
// larger odd value goes through trial division: every odd candidate divisor
// inside the table takes a bitmap read, and every prime divisor goes through
// the one-bit-per-cycle restoring remainder unit, for divisors up to
// sqrt(number) until one divides it. A candidate past the end of the table
// skips the read and goes straight to the remainder unit. The bitmap is one
// single-port-write, one-read RAM.
// The result sits in an output register, so a pending result never blocks
// acceptance of the next query.
module odd_sieve_prime_test_core
  import osp_pkg::*;
#(
  parameter int TABLE_ENTRIES = 1048576,
  parameter int NUMBER_BITS   = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [30:0] number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_prime
);

  osp_cmd_t cmd;
  osp_sts_t sts;

  // Sequencer: build, classify, look up, trial-divide.
  osp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .is_prime (is_prime),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Bitmap, divisor stepping and remainder unit.
  osp_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .NUMBER_BITS  (NUMBER_BITS)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .number(number),
    .cmd   (cmd),
    .sts   (sts)
  );

endmodule
